### hw/rtl/rrc_pkg.sv
// ----------------------------------------------------------------------------
// rrc_pkg: shared types and constants of the rectangle raster canvas
// Operation codes, shape kinds, register indexes, reset values and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package rrc_pkg;

	localparam int DEF_MAX_SIDE = 256;

	// geometry arithmetic width: Q15.8 corner plus size plus headroom
	localparam int GEO_W  = 27;
	localparam int ONE_Q8 = 256;
	// used canvas sides are held wide enough for a side of 1024
	localparam int USED_W = 11;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 9;

	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BG     = 2'd2;

	localparam logic [8:0] RST_WIDTH  = 9'd256;
	localparam logic [8:0] RST_HEIGHT = 9'd256;
	localparam logic [7:0] RST_BG     = 8'd32;

	localparam logic [1:0] OP_CLEAR = 2'd0;
	localparam logic [1:0] OP_DRAW  = 2'd1;
	localparam logic [1:0] OP_READ  = 2'd2;

	localparam logic [7:0] KIND_FILLED  = 8'd82;
	localparam logic [7:0] KIND_OUTLINE = 8'd114;

	typedef struct packed {
		logic capture;
		logic setup;
		logic sweep_start;
		logic sweep_step;
		logic load_out;
	} rrc_cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       err;
		logic       empty;
		logic       sweep_last;
		logic       out_busy;
	} rrc_sts_t;

endpackage

### hw/rtl/rectangle_raster_canvas_unit.sv
// ----------------------------------------------------------------------------
// rectangle_raster_canvas_unit: character canvas with rectangle drawing
// Clear, draw filled or outlined rectangles in Q15.8, and read back cells.
// ----------------------------------------------------------------------------
// Usage: an item on the input channel (in_valid/in_stall) is one operation:
// clear, draw rectangle or read one cell. Every item yields exactly one
// result (cell_char, status) on the output channel (out_valid/out_stall).
// Canvas size and background character come from the write-only register
// port (cfg_wr_en, cfg_index, cfg_wdata); write it only while idle.
// Sequence: a clear or a valid draw goes from acceptance through decode, a
// sweep over the w*h cells, where w and h are the used canvas sides, and a
// finish step to out_valid; the sweep writes one canvas cell per cycle
// through the single memory write port. A read, an error or an empty canvas
// skips the sweep. One item is in work at a time; the next item is taken
// once the previous result sits in the output register, even while that
// result is still stalled. Reset clears the control state and the
// registers to 256 x 256 with a space background. The canvas memory is
// not cleared: issue a clear before reading cells. While out_stall is high
// the result holds and the unit finishes at most one more item before it
// stalls its input.
module rectangle_raster_canvas_unit #(
	parameter int MAX_SIDE = rrc_pkg::DEF_MAX_SIDE
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [1:0]                     op,
	input  logic [7:0]                     shape_kind,
	input  logic signed [23:0]             corner_x,
	input  logic signed [23:0]             corner_y,
	input  logic signed [23:0]             rect_width,
	input  logic signed [23:0]             rect_height,
	input  logic [7:0]                     paint_char,
	input  logic [7:0]                     read_col,
	input  logic [7:0]                     read_row,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     cell_char,
	output logic                           status
);
	import rrc_pkg::*;

	// controller to datapath commands and status back
	rrc_cmd_t cmd;
	rrc_sts_t sts;

	// sequencer: accept, decode, sweep, hand off
	rrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// registers, geometry, canvas memory and output stage
	rrc_datapath #(
		.MAX_SIDE (MAX_SIDE)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.op          (op),
		.shape_kind  (shape_kind),
		.corner_x    (corner_x),
		.corner_y    (corner_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.paint_char  (paint_char),
		.read_col    (read_col),
		.read_row    (read_row),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_char   (cell_char),
		.status      (status),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

### hw/rtl/rrc_ctrl.sv
// ----------------------------------------------------------------------------
// rrc_ctrl: operation sequencer
// Accepts one item, decodes it, runs the cell sweep and hands the result
// to the output register.
// ----------------------------------------------------------------------------
module rrc_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  rrc_pkg::rrc_sts_t sts,
	output rrc_pkg::rrc_cmd_t cmd
);
	import rrc_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECODE,
		ST_SWEEP,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   in_stall_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.setup = 1'b1;
				if (sts.err || sts.op == OP_READ || sts.empty) begin
					state_d = ST_FINISH;
				end else begin
					cmd.sweep_start = 1'b1;
					state_d         = ST_SWEEP;
				end
			end
			ST_SWEEP: begin
				cmd.sweep_step = 1'b1;
				if (sts.sweep_last) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				// hold until the output register is free
				if (!sts.out_busy) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			in_stall_q <= (state_d != ST_IDLE);
		end
	end

	assign in_stall = in_stall_q;

endmodule

### hw/rtl/rrc_datapath.sv
// ----------------------------------------------------------------------------
// rrc_datapath: canvas memory, geometry and result register
// Holds the configuration registers, the captured item, the cell sweep
// counters with the coverage test, the canvas memory and the output stage.
// ----------------------------------------------------------------------------
module rrc_datapath #(
	parameter int MAX_SIDE = rrc_pkg::DEF_MAX_SIDE
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_wr_en,
	input  logic [rrc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rrc_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic [1:0]                     op,
	input  logic [7:0]                     shape_kind,
	input  logic signed [23:0]             corner_x,
	input  logic signed [23:0]             corner_y,
	input  logic signed [23:0]             rect_width,
	input  logic signed [23:0]             rect_height,
	input  logic [7:0]                     paint_char,
	input  logic [7:0]                     read_col,
	input  logic [7:0]                     read_row,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     cell_char,
	output logic                           status,
	input  rrc_pkg::rrc_cmd_t              cmd,
	output rrc_pkg::rrc_sts_t              sts
);
	import rrc_pkg::*;

	localparam int SIDE_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
	localparam int DEPTH  = 1 << (2 * SIDE_W);
	localparam logic [USED_W-1:0] MAX_U = USED_W'(MAX_SIDE);
	localparam logic signed [GEO_W-1:0] ONE_G = GEO_W'(ONE_Q8);

	function automatic logic signed [GEO_W-1:0] trunc_q8(input logic signed [GEO_W-1:0] v);
		logic signed [GEO_W-1:0] q;
		q = v >>> 8;
		if (v[GEO_W-1] && v[7:0] != 8'h00) begin
			q = q + GEO_W'(1);
		end
		return q;
	endfunction

	function automatic logic edge_gate(input logic signed [GEO_W-1:0] p,
		input logic signed [GEO_W-1:0] s);
		logic narrow;
		narrow = (s > 0) && (s < ONE_G) && (p[7:0] != 8'h00);
		return !narrow || (trunc_q8(p + s) > trunc_q8(p));
	endfunction

	// configuration
	logic [8:0] cfg_w_q;
	logic [8:0] cfg_h_q;
	logic [7:0] bg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_w_q <= RST_WIDTH;
			cfg_h_q <= RST_HEIGHT;
			bg_q    <= RST_BG;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_WIDTH:  cfg_w_q <= cfg_wdata;
				CFG_HEIGHT: cfg_h_q <= cfg_wdata;
				CFG_BG:     bg_q    <= cfg_wdata[7:0];
				default:    ;
			endcase
		end
	end

	logic [USED_W-1:0] w_used;
	logic [USED_W-1:0] h_used;
	assign w_used = (USED_W'(cfg_w_q) > MAX_U) ? MAX_U : USED_W'(cfg_w_q);
	assign h_used = (USED_W'(cfg_h_q) > MAX_U) ? MAX_U : USED_W'(cfg_h_q);

	// captured item
	logic [1:0]               op_q;
	logic [7:0]               kind_q;
	logic [7:0]               paint_q;
	logic signed [23:0]       rw_q;
	logic signed [23:0]       rh_q;
	logic [7:0]               rcol_q;
	logic [7:0]               rrow_q;
	logic signed [GEO_W-1:0]  tlx_q;
	logic signed [GEO_W-1:0]  tly_q;
	logic signed [GEO_W-1:0]  brx_q;
	logic signed [GEO_W-1:0]  bry_q;
	logic signed [GEO_W-1:0]  tlx1_q;
	logic signed [GEO_W-1:0]  tly1_q;
	logic                     gx_q;
	logic                     gy_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q    <= op;
			kind_q  <= shape_kind;
			paint_q <= paint_char;
			rw_q    <= rect_width;
			rh_q    <= rect_height;
			rcol_q  <= read_col;
			rrow_q  <= read_row;
			tlx_q   <= GEO_W'(corner_x);
			tly_q   <= GEO_W'(corner_y);
			brx_q   <= GEO_W'(corner_x) + GEO_W'(rect_width);
			bry_q   <= GEO_W'(corner_y) + GEO_W'(rect_height);
			tlx1_q  <= GEO_W'(corner_x) + ONE_G;
			tly1_q  <= GEO_W'(corner_y) + ONE_G;
		end
		if (cmd.setup) begin
			gx_q <= edge_gate(tlx_q, GEO_W'(rw_q));
			gy_q <= edge_gate(tly_q, GEO_W'(rh_q));
		end
	end

	// item checks
	logic bad_kind;
	logic bad_size;
	logic bad_read;
	logic err;
	assign bad_kind = (kind_q != KIND_FILLED) && (kind_q != KIND_OUTLINE);
	assign bad_size = rw_q[23] || (rw_q == 24'sd0) || rh_q[23] || (rh_q == 24'sd0);
	assign bad_read = (USED_W'(rcol_q) >= w_used) || (USED_W'(rrow_q) >= h_used);

	always_comb begin
		unique case (op_q)
			OP_CLEAR: err = 1'b0;
			OP_DRAW:  err = bad_kind || bad_size;
			OP_READ:  err = bad_read;
			default:  err = 1'b1;
		endcase
	end

	// sweep counters
	logic [SIDE_W-1:0] col_q;
	logic [SIDE_W-1:0] row_q;
	logic              col_last;
	logic              row_last;
	assign col_last = (USED_W'(col_q) + USED_W'(1)) == w_used;
	assign row_last = (USED_W'(row_q) + USED_W'(1)) == h_used;

	always_ff @(posedge clk) begin
		if (cmd.sweep_start) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.sweep_step) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_q + SIDE_W'(1);
			end else begin
				col_q <= col_q + SIDE_W'(1);
			end
		end
	end

	// coverage test of the current cell
	logic signed [GEO_W-1:0] x_c;
	logic signed [GEO_W-1:0] y_c;
	logic signed [GEO_W-1:0] xp_c;
	logic signed [GEO_W-1:0] yp_c;
	logic inx;
	logic iny;
	logic hit;
	assign x_c  = $signed(GEO_W'({col_q, 8'h00}));
	assign y_c  = $signed(GEO_W'({row_q, 8'h00}));
	assign xp_c = x_c + ONE_G;
	assign yp_c = y_c + ONE_G;
	assign inx  = (x_c >= tlx_q) && (x_c <= brx_q);
	assign iny  = (y_c >= tly_q) && (y_c <= bry_q);

	always_comb begin
		if (kind_q == KIND_FILLED) begin
			hit = inx && iny;
		end else begin
			hit = (gx_q && iny && (x_c < tlx1_q) && (x_c >= tlx_q))
			   || (gy_q && inx && (y_c < tly1_q) && (y_c >= tly_q))
			   || (gx_q && iny && (xp_c > brx_q) && (x_c <= brx_q))
			   || (gy_q && inx && (yp_c > bry_q) && (y_c <= bry_q));
		end
	end

	// canvas memory
	logic [7:0]          canvas_mem_q [DEPTH];
	logic [7:0]          rd_q;
	logic                wr_en;
	logic [7:0]          wr_data;
	logic [2*SIDE_W-1:0] wr_addr;
	logic [2*SIDE_W-1:0] rd_addr;
	assign wr_en   = cmd.sweep_step && ((op_q == OP_CLEAR) || hit);
	assign wr_data = (op_q == OP_CLEAR) ? bg_q : paint_q;
	assign wr_addr = {row_q, col_q};
	assign rd_addr = {SIDE_W'(rrow_q), SIDE_W'(rcol_q)};

	always_ff @(posedge clk) begin
		if (wr_en) begin
			canvas_mem_q[wr_addr] <= wr_data;
		end
		rd_q <= canvas_mem_q[rd_addr];
	end

	// output register
	logic       out_valid_q;
	logic [7:0] cell_char_q;
	logic       status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			cell_char_q <= (op_q == OP_READ && !err) ? rd_q : 8'h00;
			status_q    <= err;
		end
	end

	assign out_valid = out_valid_q;
	assign cell_char = cell_char_q;
	assign status    = status_q;

	assign sts.op         = op_q;
	assign sts.err        = err;
	assign sts.empty      = (w_used == '0) || (h_used == '0);
	assign sts.sweep_last = col_last && row_last;
	assign sts.out_busy   = out_valid_q && out_stall;

endmodule

### tb/sv/rectangle_raster_canvas_unit_tb.sv
// ----------------------------------------------------------------------------
// rectangle_raster_canvas_unit_tb: self-checking bench of the raster canvas
// Drives clear, draw and read items through the valid/stall input channel.
// A local copy of the canvas computes each expected cell and status, and
// every result item is checked against it. Both channels idle and stall at
// random, and the canvas registers move through small, empty and oversized
// settings between phases.
// ----------------------------------------------------------------------------
module rectangle_raster_canvas_unit_tb;

	timeunit 1ns;
	timeprecision 1ps;

	import rrc_pkg::*;

	// op code 3 is not defined by the block and must come back as an error
	localparam logic [1:0] OP_UNUSED = 2'd3;
	localparam int SIDE = DEF_MAX_SIDE;

	typedef struct {
		logic [1:0]         op;
		logic [7:0]         shape_kind;
		logic signed [23:0] corner_x;
		logic signed [23:0] corner_y;
		logic signed [23:0] rect_width;
		logic signed [23:0] rect_height;
		logic [7:0]         paint_char;
		logic [7:0]         read_col;
		logic [7:0]         read_row;
	} canvas_op_t;

	typedef struct {
		logic [7:0] cell_char;
		logic       status;
	} cell_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] op = '0;
	logic [7:0] shape_kind = '0;
	logic signed [23:0] corner_x = '0;
	logic signed [23:0] corner_y = '0;
	logic signed [23:0] rect_width = '0;
	logic signed [23:0] rect_height = '0;
	logic [7:0] paint_char = '0;
	logic [7:0] read_col = '0;
	logic [7:0] read_row = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] cell_char;
	logic status;

	// local copy of the canvas and its registers
	logic [7:0] canvas_cells [0:SIDE*SIDE-1];
	logic [8:0] width_reg = RST_WIDTH;
	logic [8:0] height_reg = RST_HEIGHT;
	logic [7:0] bg_reg = RST_BG;

	cell_result_t results_due [$];
	cell_result_t head_result;
	int mismatch_count = 0;

	// sender burst control and receiver long hold
	int burst_left = 0;
	bit gaps_on = 1'b1;
	int stall_hold_left = 0;

	rectangle_raster_canvas_unit i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.op          (op),
		.shape_kind  (shape_kind),
		.corner_x    (corner_x),
		.corner_y    (corner_y),
		.rect_width  (rect_width),
		.rect_height (rect_height),
		.paint_char  (paint_char),
		.read_col    (read_col),
		.read_row    (read_row),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.cell_char   (cell_char),
		.status      (status)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ------------------------------------------------------------------------
	// Canvas arithmetic
	// ------------------------------------------------------------------------

	// register values above the maximum side act as the maximum side
	function automatic int used_side(input logic [8:0] v);
		return (v > SIDE) ? SIDE : int'(v);
	endfunction

	// Outline edge gate: a sub-unit size on a fractional corner only opens
	// the edge when the far edge truncates to a different integer.
	function automatic bit outline_gate(input longint p, input longint s);
		if (s > 0 && s < ONE_Q8 && (p % ONE_Q8) != 0)
			return ((p + s) / ONE_Q8) > (p / ONE_Q8);
		return 1'b1;
	endfunction

	// Apply one accepted item to the local canvas and queue its result.
	function automatic void run_canvas_op(input canvas_op_t it);
		int w, h, r, c;
		longint tlx, tly, rw, rh, brx, bry, x, y;
		bit gx, gy, inx, iny, hit;
		cell_result_t res;
		w = used_side(width_reg);
		h = used_side(height_reg);
		res.cell_char = 8'd0;
		res.status = 1'b0;
		tlx = it.corner_x;
		tly = it.corner_y;
		rw = it.rect_width;
		rh = it.rect_height;
		case (it.op)
			OP_CLEAR: begin
				for (r = 0; r < h; r++)
					for (c = 0; c < w; c++)
						canvas_cells[r*SIDE+c] = bg_reg;
			end
			OP_DRAW: begin
				if ((it.shape_kind != KIND_FILLED && it.shape_kind != KIND_OUTLINE)
						|| rw <= 0 || rh <= 0) begin
					res.status = 1'b1;
				end else begin
					brx = tlx + rw;
					bry = tly + rh;
					gx = outline_gate(tlx, rw);
					gy = outline_gate(tly, rh);
					for (r = 0; r < h; r++) begin
						y = longint'(r) * ONE_Q8;
						for (c = 0; c < w; c++) begin
							x = longint'(c) * ONE_Q8;
							inx = x >= tlx && x <= brx;
							iny = y >= tly && y <= bry;
							if (it.shape_kind == KIND_FILLED)
								hit = inx && iny;
							else
								hit = (gx && iny && x >= tlx && x < tlx + ONE_Q8)
									|| (gy && inx && y >= tly && y < tly + ONE_Q8)
									|| (gx && iny && x > brx - ONE_Q8 && x <= brx)
									|| (gy && inx && y > bry - ONE_Q8 && y <= bry);
							if (hit)
								canvas_cells[r*SIDE+c] = it.paint_char;
						end
					end
				end
			end
			OP_READ: begin
				if (it.read_col >= w || it.read_row >= h)
					res.status = 1'b1;
				else
					res.cell_char = canvas_cells[int'(it.read_row)*SIDE+int'(it.read_col)];
			end
			default: res.status = 1'b1;
		endcase
		results_due.push_back(res);
	endfunction

	// ------------------------------------------------------------------------
	// Item builders: fields the op ignores carry random junk
	// ------------------------------------------------------------------------

	function automatic canvas_op_t junk_item(input logic [1:0] code);
		canvas_op_t it;
		it.op = code;
		it.shape_kind = 8'($urandom);
		it.corner_x = 24'($urandom);
		it.corner_y = 24'($urandom);
		it.rect_width = 24'($urandom);
		it.rect_height = 24'($urandom);
		it.paint_char = 8'($urandom);
		it.read_col = 8'($urandom);
		it.read_row = 8'($urandom);
		return it;
	endfunction

	function automatic canvas_op_t draw_item(input logic [7:0] kind, input longint x,
			input longint y, input longint w, input longint h, input logic [7:0] paint);
		canvas_op_t it;
		it = junk_item(OP_DRAW);
		it.shape_kind = kind;
		it.corner_x = x[23:0];
		it.corner_y = y[23:0];
		it.rect_width = w[23:0];
		it.rect_height = h[23:0];
		it.paint_char = paint;
		return it;
	endfunction

	function automatic canvas_op_t read_item(input int col, input int row);
		canvas_op_t it;
		it = junk_item(OP_READ);
		it.read_col = col[7:0];
		it.read_row = row[7:0];
		return it;
	endfunction

	// corner near the used canvas, integer or fractional
	function automatic longint near_corner(input int side);
		longint v;
		v = longint'($urandom_range(0, side + 5)) - 3;
		v = v * ONE_Q8;
		if ($urandom_range(0, 1))
			v += $urandom_range(1, ONE_Q8 - 1);
		return v;
	endfunction

	function automatic longint random_size(input int side);
		case ($urandom_range(0, 9))
			0: return $urandom_range(1, ONE_Q8 - 1);
			1: return 0;
			2: return -longint'($urandom_range(1, 8388608));
			3: return longint'($urandom_range(1, side + 3)) * ONE_Q8;
			4: return longint'(24'($urandom));
			default: return $urandom_range(1, (side + 4) * ONE_Q8);
		endcase
	endfunction

	function automatic canvas_op_t random_item();
		canvas_op_t it;
		int w, h, pick;
		w = used_side(width_reg);
		h = used_side(height_reg);
		pick = $urandom_range(0, 99);
		if (pick < 6) begin
			it = junk_item(OP_CLEAR);
		end else if (pick < 55) begin
			it = junk_item(OP_DRAW);
			if ($urandom_range(0, 99) < 85)
				it.shape_kind = $urandom_range(0, 1) ? KIND_FILLED : KIND_OUTLINE;
			if ($urandom_range(0, 99) < 85) begin
				it.corner_x = 24'(near_corner(w));
				it.corner_y = 24'(near_corner(h));
			end
			it.rect_width = 24'(random_size(w));
			it.rect_height = 24'(random_size(h));
		end else if (pick < 95) begin
			it = junk_item(OP_READ);
			// half the reads land inside the canvas, every such cell was cleared
			if ($urandom_range(0, 1)) begin
				it.read_col = 8'($urandom_range(0, w - 1));
				it.read_row = 8'($urandom_range(0, h - 1));
			end
		end else begin
			it = junk_item(OP_UNUSED);
		end
		return it;
	endfunction

	// ------------------------------------------------------------------------
	// Channel tasks
	// ------------------------------------------------------------------------

	// Offer one item and hold it until accepted; with gaps on, bursts end in a random gap.
	task automatic send_op(input canvas_op_t it);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			if (gaps_on) begin
				@(negedge clk);
				in_valid <= 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end
		end
		burst_left--;
		@(negedge clk);
		op <= it.op;
		shape_kind <= it.shape_kind;
		corner_x <= it.corner_x;
		corner_y <= it.corner_y;
		rect_width <= it.rect_width;
		rect_height <= it.rect_height;
		paint_char <= it.paint_char;
		read_col <= it.read_col;
		read_row <= it.read_row;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		run_canvas_op(it);
	endtask

	// Drop valid, drain every result, then write all three registers.
	task automatic set_canvas(input int w, input int h, input int bg);
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_index <= CFG_WIDTH;
		cfg_wdata <= w[8:0];
		@(negedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_wdata <= h[8:0];
		@(negedge clk);
		cfg_index <= CFG_BG;
		cfg_wdata <= {1'b0, bg[7:0]};
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		width_reg = w[8:0];
		height_reg = h[8:0];
		bg_reg = bg[7:0];
	endtask

	task automatic flag_error(input string msg);
		mismatch_count++;
		if (mismatch_count <= 10)
			$display("%0t: %s", $time, msg);
	endtask

	// ------------------------------------------------------------------------
	// Result checking: compare each taken result with the oldest one due
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				flag_error($sformatf("result with none due: cell_char %0d status %0d",
					cell_char, status));
			end else begin
				head_result = results_due.pop_front();
				if (cell_char !== head_result.cell_char)
					flag_error($sformatf("cell_char: want %0d got %0d",
						head_result.cell_char, cell_char));
				if (status !== head_result.status)
					flag_error($sformatf("status: want %0d got %0d",
						head_result.status, status));
			end
		end
	end

	// Receiver: runs of random stall density, plus a long hold on request.
	initial begin : receiver_stall
		int run_left;
		int stall_pct;
		run_left = 0;
		stall_pct = 0;
		forever begin
			@(negedge clk);
			if (stall_hold_left > 0) begin
				out_stall <= 1'b1;
				stall_hold_left--;
			end else if (run_left > 0) begin
				out_stall <= ($urandom_range(0, 99) < stall_pct);
				run_left--;
			end else begin
				run_left = $urandom_range(4, 80);
				case ($urandom_range(0, 3))
					0: stall_pct = 0;
					1: stall_pct = 25;
					2: stall_pct = 50;
					default: stall_pct = 85;
				endcase
				out_stall <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------------

	// Reset size 256 x 256: full clear, a big outline, a far corner read and an edge read.
	task automatic test_full_canvas();
		send_op(junk_item(OP_CLEAR));
		send_op(draw_item(KIND_OUTLINE, 24'h000A80, 24'h000300, 24'h00E000, 24'h00F000,
			8'h2A));
		send_op(read_item(255, 255));
		send_op(read_item(11, 3));
	endtask

	// Small canvas: fractional edges, field extremes, errors and reads.
	task automatic test_small_canvas();
		set_canvas(12, 9, 8'h2E);
		send_op(junk_item(OP_CLEAR));
		send_op(draw_item(KIND_FILLED, 'h180, 'h040, 'h300, 'h200, 8'h41));
		send_op(draw_item(KIND_OUTLINE, 'h100, 'h100, 'h600, 'h400, 8'h42));
		// sub-unit width that stays inside one integer cell: side edges closed
		send_op(draw_item(KIND_OUTLINE, 'h180, 'h280, 'h040, 'h300, 8'h43));
		// sub-unit sizes that cross an integer boundary: edges open
		send_op(draw_item(KIND_OUTLINE, 'h1C0, 'h0C0, 'h080, 'h080, 8'h44));
		send_op(draw_item(KIND_FILLED, -8388608, -8388608, 8388607, 8388607, 8'h45));
		send_op(draw_item(KIND_FILLED, 8388607, 8388607, 8388607, 8388607, 8'h00));
		send_op(draw_item(KIND_OUTLINE, -'h800, -'h800, 8388607, 'h1800, 8'hFF));
		send_op(draw_item(8'h00, 0, 0, 'h200, 'h200, 8'h46));
		send_op(draw_item(8'hFF, 0, 0, 'h200, 'h200, 8'h46));
		send_op(draw_item(KIND_FILLED, 0, 0, 0, 'h200, 8'h47));
		send_op(draw_item(KIND_OUTLINE, 0, 0, 'h200, -8388608, 8'h47));
		send_op(read_item(0, 0));
		send_op(read_item(11, 8));
		send_op(read_item(12, 0));
		send_op(read_item(255, 255));
		send_op(junk_item(OP_UNUSED));
	endtask

	// Empty canvas, then oversized width and height registers.
	task automatic test_canvas_extremes();
		set_canvas(0, 5, 8'h00);
		send_op(junk_item(OP_CLEAR));
		send_op(draw_item(KIND_FILLED, 0, 0, 'h400, 'h400, 8'h48));
		send_op(read_item(0, 0));
		set_canvas(511, 1, 8'hFF);
		send_op(junk_item(OP_CLEAR));
		send_op(draw_item(KIND_FILLED, 'hFA00, 0, 'h400, 'h100, 8'h49));
		send_op(read_item(253, 0));
		set_canvas(1, 511, 8'h00);
		send_op(junk_item(OP_CLEAR));
		send_op(read_item(0, 255));
	endtask

	// Hold off the receiver while reads keep coming back to back, so the
	// output register and the work slot fill and the input stalls.
	task automatic test_backpressure();
		int n;
		set_canvas(6, 6, 8'h23);
		send_op(junk_item(OP_CLEAR));
		gaps_on = 1'b0;
		stall_hold_left = 150;
		for (n = 0; n < 12; n++)
			send_op(read_item($urandom_range(0, 5), $urandom_range(0, 5)));
		gaps_on = 1'b1;
	endtask

	// Random items on small random canvases, each phase starting cleared.
	task automatic test_random_phases();
		int phase, n;
		for (phase = 0; phase < 4; phase++) begin
			set_canvas($urandom_range(1, 20), $urandom_range(1, 20), $urandom_range(0, 255));
			send_op(junk_item(OP_CLEAR));
			for (n = 0; n < 15; n++)
				send_op(random_item());
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_full_canvas();
		test_small_canvas();
		test_canvas_extremes();
		test_backpressure();
		test_random_phases();
		// drop valid, then let every due result come out
		@(negedge clk);
		in_valid <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatch_count == 0)
			$display("rectangle_raster_canvas_unit_tb OK");
		else
			$display("rectangle_raster_canvas_unit_tb NOT OK");
		$finish;
	end

	// guard against a hung handshake
	initial begin
		#20ms;
		$display("rectangle_raster_canvas_unit_tb NOT OK");
		$finish;
	end

endmodule
